@@ src/fast_float_square_root_top_assert.svh @@
// Assertion macros shared by the approximate square root block.
// Depends on nothing; included by the top level only.
`ifndef FAST_FLOAT_SQUARE_ROOT_TOP_ASSERT_SVH
`define FAST_FLOAT_SQUARE_ROOT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle, outside reset.
`define FFSR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFSR_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/ffsr_pkg.sv @@
// Types, constants and float helpers for the approximate square root block.
// Depends on nothing; used by the round, multiply, subtract and top-level files and the testbench.
package ffsr_pkg;

   localparam int PROD_W = 50;
   localparam int EXP_W  = 12;

   localparam logic [31:0] ISR_MAGIC         = 32'h5f3759df;
   localparam logic [31:0] HALF_BITS         = 32'h3f000000;
   localparam logic [31:0] THREE_HALVES_BITS = 32'h3fc00000;
   localparam logic [31:0] DEFAULT_NAN       = 32'hffc00000;
   localparam logic [31:0] QUIET_BIT         = 32'h00400000;
   localparam logic [32:0] OVERFLOW_LIMIT    = 33'h07f800000;

   typedef struct packed {
      logic [31:0] operand_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] root_bits;
   } rsp_type;

   typedef struct packed {
      logic [31:0] number;
      logic [31:0] half;
      logic [31:0] y;
   } side_type;

   typedef struct packed {
      logic                    sign;
      logic                    special;
      logic [31:0]             special_bits;
      logic [PROD_W-1:0]       prod;
      logic signed [EXP_W-1:0] exp;
   } norm_type;

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input logic [31:0] x);
      return x[30:0] == 31'd0;
   endfunction

   function automatic logic [23:0] mant_of(input logic [31:0] x);
      return {x[30:23] != 8'd0, x[22:0]};
   endfunction

   function automatic logic [7:0] exp_of(input logic [31:0] x);
      return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
   endfunction

endpackage

@@ src/ffsr_chan_if.sv @@
// Valid/ready channel carrying one payload per transaction.
// Depends on nothing; the payload type is given at instantiation.
interface ffsr_chan_if #(parameter type payload_type = logic [31:0]);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/ffsr_round.sv @@
// Normalisation and round-to-nearest-even packing, two register stages.
// Depends on ffsr_pkg.
module ffsr_round import ffsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  norm_type norm_in,
   input  side_type side_in,
   output logic     out_valid,
   output logic [31:0] res,
   output side_type side_out
);

   logic [5:0]              msb;
   logic signed [EXP_W-1:0] be;
   logic signed [EXP_W-1:0] kraw;
   logic [6:0]              k;
   logic [127:0]            wide;
   logic [8:0]              efield_in;

   logic                    v2_ff;
   logic [24:0]             q_ff;
   logic                    sticky_ff;
   logic [8:0]              efield_ff;
   logic                    zero_ff;
   logic                    sign_ff;
   logic                    special_ff;
   logic [31:0]             special_bits_ff;
   side_type                side2_ff;

   logic [23:0]             mant;
   logic                    inc;
   logic [32:0]             sum;
   logic [31:0]             res_in;

   logic                    v3_ff;
   logic [31:0]             res_ff;
   side_type                side3_ff;

   always_comb begin
      msb = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (norm_in.prod[i]) begin
            msb = 6'(i);
         end
      end
      be = $signed({{(EXP_W-6){1'b0}}, msb}) + norm_in.exp + EXP_W'(127);
      if (be >= 1) begin
         kraw      = $signed({{(EXP_W-6){1'b0}}, msb});
         efield_in = 9'(be - EXP_W'(1));
      end else begin
         kraw      = -EXP_W'(126) - norm_in.exp;
         efield_in = '0;
      end
      k    = (kraw > 78) ? 7'd78 : 7'(kraw);
      wide = {norm_in.prod, 78'd0} >> k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= in_valid;
      end
      if (en) begin
         q_ff            <= wide[78:54];
         sticky_ff       <= |wide[53:0];
         efield_ff       <= efield_in;
         zero_ff         <= norm_in.prod == '0;
         sign_ff         <= norm_in.sign;
         special_ff      <= norm_in.special;
         special_bits_ff <= norm_in.special_bits;
         side2_ff        <= side_in;
      end
   end

   always_comb begin
      mant = q_ff[24:1];
      inc  = q_ff[0] & (sticky_ff | q_ff[1]);
      sum  = {1'b0, efield_ff, 23'd0} + {9'd0, mant} + {32'd0, inc};
      if (special_ff) begin
         res_in = special_bits_ff;
      end else if (zero_ff) begin
         res_in = {sign_ff, 31'd0};
      end else if (sum >= OVERFLOW_LIMIT) begin
         res_in = {sign_ff, 8'hff, 23'd0};
      end else begin
         res_in = {sign_ff, sum[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         res_ff   <= res_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign res       = res_ff;
   assign side_out  = side3_ff;

endmodule

@@ src/ffsr_fmul.sv @@
// Single-precision multiplier: significand product stage, then rounding.
// Depends on ffsr_pkg and ffsr_round.
module ffsr_fmul import ffsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  side_type    side_in,
   output logic        out_valid,
   output logic [31:0] res,
   output side_type    side_out
);

   norm_type norm_in;
   logic     v1_ff;
   norm_type norm_ff;
   side_type side1_ff;

   always_comb begin
      norm_in.sign         = a[31] ^ b[31];
      norm_in.special      = 1'b1;
      norm_in.special_bits = '0;
      norm_in.prod         = PROD_W'(mant_of(a)) * PROD_W'(mant_of(b));
      norm_in.exp          = $signed({4'd0, exp_of(a)}) + $signed({4'd0, exp_of(b)})
                             - EXP_W'(300);
      if (is_nan(a)) begin
         norm_in.special_bits = a | QUIET_BIT;
      end else if (is_nan(b)) begin
         norm_in.special_bits = b | QUIET_BIT;
      end else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
         norm_in.special_bits = DEFAULT_NAN;
      end else if (is_inf(a) || is_inf(b)) begin
         norm_in.special_bits = {a[31] ^ b[31], 8'hff, 23'd0};
      end else begin
         norm_in.special = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         norm_ff  <= norm_in;
         side1_ff <= side_in;
      end
   end

   ffsr_round u_round (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .norm_in   (norm_ff),
      .side_in   (side1_ff),
      .out_valid (out_valid),
      .res       (res),
      .side_out  (side_out)
   );

endmodule

@@ src/ffsr_fsub.sv @@
// Single-precision subtractor: alignment and add stage, then rounding.
// Depends on ffsr_pkg and ffsr_round.
module ffsr_fsub import ffsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  side_type    side_in,
   output logic        out_valid,
   output logic [31:0] res,
   output side_type    side_out
);

   logic [31:0] bn;
   logic [31:0] big;
   logic [31:0] sml;
   logic [7:0]  d;
   logic [26:0] mb;
   logic [26:0] ms;
   logic [26:0] al;
   logic [27:0] total;
   norm_type    norm_in;
   logic        v1_ff;
   norm_type    norm_ff;
   side_type    side1_ff;

   always_comb begin
      bn = {~b[31], b[30:0]};
      if (a[30:0] >= bn[30:0]) begin
         big = a;
         sml = bn;
      end else begin
         big = bn;
         sml = a;
      end
      d  = exp_of(big) - exp_of(sml);
      mb = {mant_of(big), 3'd0};
      ms = {mant_of(sml), 3'd0};
      if (d >= 8'd27) begin
         al = {26'd0, |ms};
      end else begin
         al = (ms >> d) | {26'd0, |(ms & ((27'd1 << d) - 27'd1))};
      end
      if (big[31] == sml[31]) begin
         total = {1'b0, mb} + {1'b0, al};
      end else begin
         total = {1'b0, mb} - {1'b0, al};
      end
      norm_in.prod = {{(PROD_W-28){1'b0}}, total};
      norm_in.exp  = $signed({4'd0, exp_of(big)}) - EXP_W'(153);
      norm_in.sign = (total == 28'd0) ? (a[31] & bn[31]) : big[31];
      norm_in.special      = 1'b1;
      norm_in.special_bits = '0;
      if (is_nan(a)) begin
         norm_in.special_bits = a | QUIET_BIT;
      end else if (is_nan(b)) begin
         norm_in.special_bits = b | QUIET_BIT;
      end else if (is_inf(a) && is_inf(bn) && (a[31] != bn[31])) begin
         norm_in.special_bits = DEFAULT_NAN;
      end else if (is_inf(a)) begin
         norm_in.special_bits = a;
      end else if (is_inf(bn)) begin
         norm_in.special_bits = bn;
      end else begin
         norm_in.special = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         norm_ff  <= norm_in;
         side1_ff <= side_in;
      end
   end

   ffsr_round u_round (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .norm_in   (norm_ff),
      .side_in   (side1_ff),
      .out_valid (out_valid),
      .res       (res),
      .side_out  (side_out)
   );

endmodule

@@ src/fast_float_square_root_top.sv @@
// Approximate single-precision square root through an inverse square root seed.
// Usage: an operand transaction enters on req_chan (payload operand_bits, raw
// IEEE single-precision bits); its root leaves on rsp_chan (payload root_bits).
// Both channels are valid/ready; a transaction moves when valid and ready are
// both high at a rising clock edge. Every operand gives exactly one result,
// in order.
// The datapath is a chain of ten float operations (eight multiplies and two
// subtractions), each three register stages deep. A new operand is accepted
// in every cycle while the output is free, giving one result per cycle.
// The last stage is the output register. When it holds a result the receiver
// does not take, the whole chain holds and req_chan.ready is low; nothing is
// lost or repeated. Synchronous reset clears all valid bits; the block
// accepts operands in the cycle after reset is released.
// Depends on ffsr_pkg, ffsr_chan_if, ffsr_fmul, ffsr_fsub and the assert header.
`include "fast_float_square_root_top_assert.svh"

module fast_float_square_root_top import ffsr_pkg::*; (
   input logic         clock,
   input logic         reset,
   ffsr_chan_if.sink   req_chan,
   ffsr_chan_if.source rsp_chan
);

   logic        en;
   logic [31:0] word;
   logic [31:0] seed;
   side_type    first_side;
   logic        half_v;
   logic [31:0] half_res;
   side_type    half_side;
   logic        nv [0:2];
   side_type    ns [0:2];
   logic        root_v;
   logic [31:0] root_res;
   side_type    root_side;

   assign en         = !rsp_chan.valid || rsp_chan.ready;
   assign word       = req_chan.payload.operand_bits;
   assign seed       = ISR_MAGIC - {word[31], word[31:1]};
   assign first_side = '{number: word, half: 32'd0, y: seed};

   ffsr_fmul u_half (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (req_chan.valid), .a (word), .b (HALF_BITS), .side_in (first_side),
      .out_valid (half_v), .res (half_res), .side_out (half_side)
   );

   assign nv[0] = half_v;
   assign ns[0] = '{number: half_side.number, half: half_res, y: half_side.y};

   for (genvar g = 0; g < 2; g++) begin : g_newton
      logic        t1_v;
      logic [31:0] t1_res;
      side_type    t1_side;
      logic        t2_v;
      logic [31:0] t2_res;
      side_type    t2_side;
      logic        c_v;
      logic [31:0] c_res;
      side_type    c_side;
      logic        y_v;
      logic [31:0] y_res;
      side_type    y_side;

      ffsr_fmul u_t1 (
         .clock (clock), .reset (reset), .en (en),
         .in_valid (nv[g]), .a (ns[g].half), .b (ns[g].y), .side_in (ns[g]),
         .out_valid (t1_v), .res (t1_res), .side_out (t1_side)
      );

      ffsr_fmul u_t2 (
         .clock (clock), .reset (reset), .en (en),
         .in_valid (t1_v), .a (t1_res), .b (t1_side.y), .side_in (t1_side),
         .out_valid (t2_v), .res (t2_res), .side_out (t2_side)
      );

      ffsr_fsub u_corr (
         .clock (clock), .reset (reset), .en (en),
         .in_valid (t2_v), .a (THREE_HALVES_BITS), .b (t2_res), .side_in (t2_side),
         .out_valid (c_v), .res (c_res), .side_out (c_side)
      );

      ffsr_fmul u_y (
         .clock (clock), .reset (reset), .en (en),
         .in_valid (c_v), .a (c_side.y), .b (c_res), .side_in (c_side),
         .out_valid (y_v), .res (y_res), .side_out (y_side)
      );

      assign nv[g+1] = y_v;
      assign ns[g+1] = '{number: y_side.number, half: y_side.half, y: y_res};
   end

   ffsr_fmul u_root (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (nv[2]), .a (ns[2].number), .b (ns[2].y), .side_in (ns[2]),
      .out_valid (root_v), .res (root_res), .side_out (root_side)
   );

   assign req_chan.ready   = en;
   assign rsp_chan.valid   = root_v;
   assign rsp_chan.payload = '{root_bits: root_res};

   `FFSR_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready)
   `FFSR_ASSERT_IMPLY(a_free_output_ready, clock, reset, !rsp_chan.valid, req_chan.ready)
   `FFSR_ASSERT_NEXT(a_reset_clears_output, clock, reset, !rsp_chan.valid)

endmodule

@@ sim/fast_float_square_root_top_test.sv @@
// Self-checking testbench for the approximate square root block: operands are
// driven on req_chan and every root on rsp_chan is compared with a bit-exact
// single-precision predictor. Depends on ffsr_pkg, ffsr_chan_if and the top level.
`timescale 1ns / 1ps

module fast_float_square_root_top_test;
   import ffsr_pkg::*;

   typedef struct {
      logic [31:0] operand;
      bit          known;
      logic [31:0] root;
   } vector_type;

   logic clock;
   logic reset;
   int   src_idle;
   int   sink_stall;
   int   mismatches;
   logic [31:0] pending_roots[$];

   ffsr_chan_if #(.payload_type(req_type)) req_chan();
   ffsr_chan_if #(.payload_type(rsp_type)) rsp_chan();

   fast_float_square_root_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] pack_round(input logic s, input logic [127:0] mag,
                                              input int e);
      int p;
      int ex;
      int sh;
      logic [127:0] keep;
      logic [127:0] rem;
      logic [127:0] half;
      logic [32:0]  bits;
      if (mag == 0) begin
         return {s, 31'd0};
      end
      p = 127;
      while (!mag[p]) p--;
      ex = p + e;
      if (ex > 127) begin
         return {s, 8'hff, 23'd0};
      end
      sh = ((ex >= -126) ? ex - 23 : -149) - e;
      if (sh <= 0) begin
         keep = mag << (-sh);
      end else if (sh >= 128) begin
         keep = 0;
      end else begin
         keep = mag >> sh;
         rem  = mag - (keep << sh);
         half = 128'd1 << (sh - 1);
         if (rem > half || (rem == half && keep[0])) keep++;
      end
      bits = ((ex >= -126) ? (33'(ex + 126) << 23) : 33'd0) + keep[32:0];
      if (bits >= 33'h07f800000) begin
         return {s, 8'hff, 23'd0};
      end
      return {s, bits[30:0]};
   endfunction

   function automatic bit nan_bits(input logic [31:0] x);
      return x[30:23] == 8'hff && x[22:0] != 0;
   endfunction

   function automatic bit inf_bits(input logic [31:0] x);
      return x[30:23] == 8'hff && x[22:0] == 0;
   endfunction

   function automatic int lsb_exp(input logic [31:0] x);
      return ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 150;
   endfunction

   function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
      logic         s;
      logic [127:0] mag;
      s = a[31] ^ b[31];
      if (nan_bits(a)) return a | QUIET_BIT;
      if (nan_bits(b)) return b | QUIET_BIT;
      if (inf_bits(a) || inf_bits(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return DEFAULT_NAN;
         return {s, 8'hff, 23'd0};
      end
      mag = 128'({a[30:23] != 0, a[22:0]}) * 128'({b[30:23] != 0, b[22:0]});
      return pack_round(s, mag, lsb_exp(a) + lsb_exp(b));
   endfunction

   function automatic logic [31:0] single_sub(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]  nb;
      logic [31:0]  big;
      logic [31:0]  lit;
      logic [127:0] mbig;
      logic [127:0] mlit;
      int           d;
      if (nan_bits(a)) return a | QUIET_BIT;
      if (nan_bits(b)) return b | QUIET_BIT;
      nb = {~b[31], b[30:0]};
      if (inf_bits(a) && inf_bits(nb)) return (a[31] == nb[31]) ? a : DEFAULT_NAN;
      if (inf_bits(a)) return a;
      if (inf_bits(nb)) return nb;
      if (lsb_exp(a) >= lsb_exp(nb)) begin
         big = a;
         lit = nb;
      end else begin
         big = nb;
         lit = a;
      end
      d = lsb_exp(big) - lsb_exp(lit);
      if (d > 60) d = 60;
      mbig = 128'({big[30:23] != 0, big[22:0]}) << d;
      mlit = 128'({lit[30:23] != 0, lit[22:0]});
      if (big[31] == lit[31]) begin
         return pack_round(big[31], mbig + mlit, lsb_exp(big) - d);
      end
      if (mbig == mlit) begin
         return 32'd0;
      end
      if (mbig > mlit) begin
         return pack_round(big[31], mbig - mlit, lsb_exp(big) - d);
      end
      return pack_round(lit[31], mlit - mbig, lsb_exp(big) - d);
   endfunction

   function automatic logic [31:0] approx_root(input logic [31:0] operand);
      logic [31:0] half;
      logic [31:0] y;
      logic [31:0] t;
      half = single_mul(operand, HALF_BITS);
      y = ISR_MAGIC - {operand[31], operand[31:1]};
      repeat (2) begin
         t = single_mul(half, y);
         t = single_mul(t, y);
         y = single_mul(y, single_sub(THREE_HALVES_BITS, t));
      end
      return single_mul(operand, y);
   endfunction

   function automatic logic [31:0] random_operand();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(3))
         0: ;
         1: begin
            case ($urandom_range(3))
               0: w[30:23] = 8'h00;
               1: w[30:23] = 8'h01;
               2: w[30:23] = 8'hfe;
               default: w[30:23] = 8'hff;
            endcase
         end
         2: w[31:23] = {1'b0, 8'($urandom_range(100, 154))};
         default: w[31:23] = {1'b0, 8'($urandom_range(1, 254))};
      endcase
      return w;
   endfunction

   task automatic send_operand(input logic [31:0] operand, input bit known,
                               input logic [31:0] root);
      while ($urandom_range(99) < src_idle) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.payload.operand_bits = operand;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_roots.push_back(known ? root : approx_root(operand));
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= sink_stall);
   end

   always @(posedge clock) begin
      logic [31:0] wanted;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_roots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected root %h", rsp_chan.payload.root_bits);
            end
         end else begin
            wanted = pending_roots.pop_front();
            if (rsp_chan.payload.root_bits !== wanted) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("root_bits mismatch: expected %h actual %h",
                           wanted, rsp_chan.payload.root_bits);
               end
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      vector_type vectors[$];
      int idle_plan[4];
      int stall_plan[4];
      clock = 1'b0;
      reset = 1'b1;
      mismatches = 0;
      src_idle = 0;
      sink_stall = 0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      idle_plan = '{0, 66, 0, 14};
      stall_plan = '{0, 0, 66, 14};
      vectors = '{
         '{32'h00000000, 1, 32'h00000000}, '{32'h7f800000, 1, 32'h7f800000},
         '{32'h7fc00000, 1, 32'h7fc00000}, '{32'h80000000, 0, 0},
         '{32'hff800000, 0, 0}, '{32'h7f800001, 0, 0}, '{32'hffffffff, 0, 0},
         '{32'h7fffffff, 0, 0}, '{32'h00000001, 0, 0}, '{32'h80000001, 0, 0},
         '{32'h807fffff, 0, 0}, '{32'h007fffff, 0, 0}, '{32'h00800000, 0, 0},
         '{32'h00400000, 0, 0}, '{32'h7f7fffff, 0, 0}, '{32'hff7fffff, 0, 0},
         '{32'h3f800000, 0, 0}, '{32'h40800000, 0, 0}, '{32'hbf800000, 0, 0},
         '{32'h3e800000, 0, 0}, '{32'h5f3759df, 0, 0}, '{32'haaaaaaaa, 0, 0},
         '{32'h55555555, 0, 0}
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (vectors[i]) begin
         send_operand(vectors[i].operand, vectors[i].known, vectors[i].root);
      end
      for (int phase = 0; phase < 4; phase++) begin
         src_idle = idle_plan[phase];
         sink_stall = stall_plan[phase];
         repeat (310) send_operand(random_operand(), 0, 0);
      end
      while (pending_roots.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_roots.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
